// ===== hdl/lzd_pkg.sv =====
package lzd_pkg;

  localparam int unsigned WINDOW_DEFAULT = 32768;
  localparam int unsigned LANES          = 4;
  localparam int unsigned LANE_IDX_W     = $clog2(LANES);
  localparam int unsigned COUNT_W        = 3;
  localparam int unsigned OFFSET_W       = 16;
  localparam int unsigned LENGTH_W       = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_HOLD
  } eng_state_e;

  typedef struct packed {
    logic [LANES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]    count;
    logic                  last;
    logic                  bad;
  } beat_t;

endpackage

// ===== hdl/lzd_if.sv =====
interface lzd_tok_if;
  logic        valid;
  logic        ready;
  logic        first_token;
  logic        token_kind;
  logic [7:0]  literal_byte;
  logic [15:0] match_offset;
  logic [7:0]  match_length;

  modport source (
    output valid, first_token, token_kind, literal_byte, match_offset, match_length,
    input  ready
  );
  modport sink (
    input  valid, first_token, token_kind, literal_byte, match_offset, match_length,
    output ready
  );
endinterface

interface lzd_beat_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       last_beat;
  logic       bad_offset;

  modport source (
    output valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count, last_beat,
           bad_offset,
    input  ready
  );
  modport sink (
    input  valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count, last_beat,
           bad_offset,
    output ready
  );
endinterface

// ===== hdl/lzd_ring.sv =====
module lzd_ring #(
  parameter int unsigned WINDOW = lzd_pkg::WINDOW_DEFAULT,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [WINDOW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lzd_engine.sv =====
module lzd_engine #(
  parameter int unsigned WINDOW = lzd_pkg::WINDOW_DEFAULT,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lzd_tok_if.sink        tok_i,
  output logic           push_valid_o,
  output lzd_pkg::beat_t beat_o,
  input  logic           push_ready_i,
  output logic           ring_we_o,
  output logic [AW-1:0]  ring_waddr_o,
  output logic [7:0]     ring_wdata_o,
  output logic           ring_re_o,
  output logic [AW-1:0]  ring_raddr_o,
  input  logic [7:0]     ring_rdata_i
);
  import lzd_pkg::*;

  localparam int unsigned FW   = $clog2(WINDOW + 1);
  localparam int unsigned DW   = OFFSET_W + 1;

  eng_state_e            state_q, state_d;
  logic [AW-1:0]         wp_q, wp_d;
  logic [AW-1:0]         rp_q, rp_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [LENGTH_W-1:0]   iss_q, iss_d;
  logic [LENGTH_W-1:0]   arr_q, arr_d;
  logic                  infl_q, infl_d;
  logic                  off1_q, off1_d;
  logic                  started_q, started_d;
  logic [LANES-1:0][7:0] lanes_q, lanes_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic [7:0]            last_byte_q, last_byte_d;
  logic                  bad_q, bad_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(WINDOW - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [FW-1:0] fill_inc(input logic [FW-1:0] f);
    return (f == FW'(WINDOW)) ? f : f + FW'(1);
  endfunction

  always_comb begin
    logic [FW-1:0]      fill_base;
    logic [DW-1:0]      diff;
    logic [7:0]         byte_in;
    logic [COUNT_W-1:0] cnt_n;
    logic               last_in;
    logic               beat_done;
    logic               bad;

    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    fill_d       = fill_q;
    iss_d        = iss_q;
    arr_d        = arr_q;
    infl_d       = infl_q;
    off1_d       = off1_q;
    started_d    = started_q;
    lanes_d      = lanes_q;
    cnt_d        = cnt_q;
    last_byte_d  = last_byte_q;
    bad_d        = bad_q;

    ring_we_o    = 1'b0;
    ring_waddr_o = wp_q;
    ring_wdata_o = '0;
    ring_re_o    = 1'b0;
    ring_raddr_o = rp_q;
    push_valid_o = 1'b0;
    beat_o       = '{bytes: lanes_q, count: cnt_q, last: (arr_q == '0), bad: bad_q};
    tok_i.ready  = (state_q == ST_IDLE);

    fill_base = tok_i.first_token ? '0 : fill_q;
    diff      = DW'(wp_q) - DW'(tok_i.match_offset);
    byte_in   = (off1_q && started_q) ? last_byte_q : ring_rdata_i;
    cnt_n     = cnt_q + COUNT_W'(infl_q);
    last_in   = infl_q && (arr_q == LENGTH_W'(1));
    beat_done = infl_q && ((cnt_n == COUNT_W'(LANES)) || last_in);
    bad       = (tok_i.match_offset == '0)
             || (32'(tok_i.match_offset) > 32'(fill_base))
             || (32'(tok_i.match_offset) > 32'(WINDOW));

    unique case (state_q)
      ST_IDLE: begin
        if (tok_i.valid) begin
          fill_d  = fill_base;
          lanes_d = '0;
          cnt_d   = '0;
          bad_d   = 1'b0;
          arr_d   = '0;
          iss_d   = '0;
          infl_d  = 1'b0;
          if (!tok_i.token_kind) begin
            ring_we_o    = 1'b1;
            ring_wdata_o = tok_i.literal_byte;
            wp_d         = ptr_inc(wp_q);
            fill_d       = fill_inc(fill_base);
            last_byte_d  = tok_i.literal_byte;
            lanes_d[0]   = tok_i.literal_byte;
            cnt_d        = COUNT_W'(1);
            state_d      = ST_HOLD;
          end else if (tok_i.match_length != '0) begin
            if (bad) begin
              bad_d   = 1'b1;
              state_d = ST_HOLD;
            end else begin
              rp_d      = diff[DW-1] ? AW'(diff + DW'(WINDOW)) : AW'(diff);
              iss_d     = tok_i.match_length;
              arr_d     = tok_i.match_length;
              off1_d    = (tok_i.match_offset == OFFSET_W'(1));
              started_d = 1'b0;
              state_d   = ST_COPY;
            end
          end
        end
      end
      ST_COPY: begin
        infl_d = 1'b0;
        if (infl_q) begin
          ring_we_o                 = 1'b1;
          ring_wdata_o              = byte_in;
          wp_d                      = ptr_inc(wp_q);
          fill_d                    = fill_inc(fill_q);
          last_byte_d               = byte_in;
          lanes_d[cnt_q[LANE_IDX_W-1:0]] = byte_in;
          cnt_d                     = cnt_n;
          arr_d                     = arr_q - LENGTH_W'(1);
          started_d                 = 1'b1;
        end
        if (beat_done) begin
          beat_o = '{bytes: lanes_d, count: cnt_n, last: last_in, bad: 1'b0};
          if (push_ready_i) begin
            push_valid_o = 1'b1;
            lanes_d      = '0;
            cnt_d        = '0;
            if (last_in) begin
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_HOLD;
          end
        end
        if ((iss_q != '0) && (!beat_done || push_ready_i)) begin
          ring_re_o = 1'b1;
          rp_d      = ptr_inc(rp_q);
          iss_d     = iss_q - LENGTH_W'(1);
          infl_d    = 1'b1;
        end
      end
      ST_HOLD: begin
        if (push_ready_i) begin
          push_valid_o = 1'b1;
          lanes_d      = '0;
          cnt_d        = '0;
          bad_d        = 1'b0;
          state_d      = (arr_q == '0) ? ST_IDLE : ST_COPY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      iss_q     <= '0;
      arr_q     <= '0;
      infl_q    <= 1'b0;
      off1_q    <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      bad_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      iss_q     <= iss_d;
      arr_q     <= arr_d;
      infl_q    <= infl_d;
      off1_q    <= off1_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      bad_q     <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q        <= rp_d;
    lanes_q     <= lanes_d;
    last_byte_q <= last_byte_d;
  end

endmodule

// ===== hdl/lzd_out_reg.sv =====
module lzd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  lzd_pkg::beat_t beat_i,
  output logic           push_ready_o,
  lzd_beat_if.source     beat_o
);
  import lzd_pkg::*;

  logic  full_q;
  beat_t data_q;

  assign push_ready_o = !full_q || beat_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (push_valid_i) begin
      full_q <= 1'b1;
    end else if (beat_o.ready) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      data_q <= beat_i;
    end
  end

  assign beat_o.valid      = full_q;
  assign beat_o.out_byte0  = data_q.bytes[0];
  assign beat_o.out_byte1  = data_q.bytes[1];
  assign beat_o.out_byte2  = data_q.bytes[2];
  assign beat_o.out_byte3  = data_q.bytes[3];
  assign beat_o.byte_count = data_q.count;
  assign beat_o.last_beat  = data_q.last;
  assign beat_o.bad_offset = data_q.bad;

endmodule

// ===== hdl/lz77_token_decompressor.sv =====
// LZ77 token decoder. It takes one token at a time and returns its bytes in beats of up
// to four, lowest byte first, through an output register. A literal gives one beat. A
// match copies one byte per cycle, while the output side does not stall, through the
// single read port of the WINDOW-byte history memory, whose registered read is covered
// by pipelining. A match whose offset is zero or reaches past the history of the
// current stream gives one beat with bad_offset set and no bytes, and a zero-length
// match gives no beat at all. The first_token flag starts a new stream with empty history.
// The history memory is not cleared after reset; no clearing pass is needed.
module lz77_token_decompressor #(
  parameter int unsigned WINDOW = lzd_pkg::WINDOW_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzd_tok_if.sink    tok_i,
  lzd_beat_if.source beat_o
);
  import lzd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);

  logic          push_valid;
  logic          push_ready;
  beat_t         beat;
  logic          ring_we;
  logic [AW-1:0] ring_waddr;
  logic [7:0]    ring_wdata;
  logic          ring_re;
  logic [AW-1:0] ring_raddr;
  logic [7:0]    ring_rdata;

  lzd_engine #(
    .WINDOW(WINDOW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_i),
    .push_valid_o(push_valid),
    .beat_o      (beat),
    .push_ready_i(push_ready),
    .ring_we_o   (ring_we),
    .ring_waddr_o(ring_waddr),
    .ring_wdata_o(ring_wdata),
    .ring_re_o   (ring_re),
    .ring_raddr_o(ring_raddr),
    .ring_rdata_i(ring_rdata)
  );

  lzd_ring #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  lzd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .beat_i      (beat),
    .push_ready_o(push_ready),
    .beat_o      (beat_o)
  );

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("beat pushed into a full output register");

  a_mid_beat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !beat.last) |-> (beat.count == COUNT_W'(LANES)))
    else $error("beat before the last one of a token is not full");

  a_bad_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && beat.bad) |-> (beat.last && (beat.count == '0)))
    else $error("error beat carries bytes or is not the last beat");

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.ready |-> !push_valid)
    else $error("beat pushed while no token is in work");
`endif

endmodule
